// ===== sv/bqc_pkg.sv =====
// shared types and constants of the band-pass biquad cascade
`timescale 1ns / 1ps
package bqc_pkg;

  // configuration register widths
  localparam int unsigned B0_W    = 17;
  localparam int unsigned A_W     = 18;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;

  // coefficient operand of the shared multiplier: holds +/-2*b0 and -a
  localparam int unsigned COEF_W  = 19;

  // tap counter: five products per section, plus an accumulator drain step
  localparam int unsigned TAP_W   = 3;
  localparam logic [TAP_W-1:0] TAP_X0   = 3'd0;
  localparam logic [TAP_W-1:0] TAP_X1   = 3'd1;
  localparam logic [TAP_W-1:0] TAP_X2   = 3'd2;
  localparam logic [TAP_W-1:0] TAP_Y1   = 3'd3;
  localparam logic [TAP_W-1:0] TAP_Y2   = 3'd4;
  localparam logic [TAP_W-1:0] TAP_LAST = 3'd5;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_B0 = 3'd0,
    REG_HP_A1 = 3'd1,
    REG_HP_A2 = 3'd2,
    REG_LP_B0 = 3'd3,
    REG_LP_A1 = 3'd4,
    REG_LP_A2 = 3'd5
  } cfg_reg_e;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic mul_en;    // register a new product
    logic acc_en;    // add the registered product
    logic acc_load;  // first product of a section replaces the sum
  } mac_ctrl_t;

endpackage

// ===== sv/bqc_mac.sv =====
// shared multiply-accumulate unit with round-half-up and clamp of the sum
`timescale 1ns / 1ps
module bqc_mac #(
  parameter int unsigned HW   = 24,
  parameter int unsigned FRAC = 16
) (
  input  logic                              clk_i,
  input  bqc_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [bqc_pkg::COEF_W-1:0] coef_i,
  input  logic signed [HW-1:0]              data_i,
  output logic signed [HW-1:0]              y_o,
  output logic                              sat_o
);
  import bqc_pkg::*;

  localparam int unsigned PROD_W = COEF_W + HW;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned RW     = (ACC_W + 1 > HW + FRAC + 1) ? ACC_W + 1 : HW + FRAC + 1;
  localparam int unsigned SHW    = RW - FRAC;
  localparam logic signed [RW-1:0] RND_HALF = RW'(1) <<< (FRAC - 1);
  localparam logic signed [HW-1:0] Y_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] Y_MIN = {1'b1, {(HW-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [RW-1:0]     rsum;
  logic signed [SHW-1:0]    rsh;
  logic [SHW-HW:0]          top_bits;
  logic                     in_range;

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= coef_i * data_i;
    end
  end

  // accumulator
  always_comb begin
    if (ctrl_i.acc_load) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // round half up by the coefficient fraction, then clamp to the history width
  assign rsum     = RW'(acc_q) + RND_HALF;
  assign rsh      = SHW'(rsum >>> FRAC);
  assign top_bits = rsh[SHW-1:HW-1];
  assign in_range = (&top_bits) || !(|top_bits);

  always_comb begin
    if (in_range) begin
      y_o = rsh[HW-1:0];
    end else if (rsh[SHW-1]) begin
      y_o = Y_MIN;
    end else begin
      y_o = Y_MAX;
    end
  end

  assign sat_o = !in_range;

endmodule

// ===== sv/biquad_cascade_bandpass_top.sv =====
// top level of the band-pass biquad cascade: registers, history, sequencer, output stage
`timescale 1ns / 1ps
// Band-pass filter built from a high-pass biquad followed by a low-pass biquad,
// both direct form I with GUARD_BITS extra fraction bits in all history but the
// input samples. All ten products go through one shared multiplier, one product a
// cycle: each section runs five products and an accumulator drain, then a
// rounding step, and a last step loads the output register. The result is shown
// in that output register, and the next word can be accepted while it waits; the
// block holds its output state only if a finished result is still not taken.
// Coefficients are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, as the block does not enforce it.
// restart_i clears all history before its own sample.
module biquad_cascade_bandpass_top #(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 16,
  parameter int unsigned GUARD_BITS     = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bqc_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o,
  output logic                                 saturated_o
);
  import bqc_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned HW = SAMPLE_BITS + GUARD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_RND  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // coefficient registers
  logic        [B0_W-1:0] hp_b0_q, lp_b0_q;
  logic signed [A_W-1:0]  hp_a1_q, hp_a2_q, lp_a1_q, lp_a2_q;

  // history
  logic signed [SB-1:0] hp_in_q  [2];
  logic signed [HW-1:0] hp_out_q [2];
  logic signed [HW-1:0] lp_in_q  [2];
  logic signed [HW-1:0] lp_out_q [2];
  logic signed [SB-1:0] x0_q;

  // sequencer
  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             sec_q, sec_d;
  logic             sat_q;

  // output register
  logic                 out_valid_q;
  logic signed [SB-1:0] sample_out_q;
  logic                 saturated_q;

  logic in_acc;
  logic out_free;
  logic out_load;

  mac_ctrl_t                mac_ctrl;
  logic signed [COEF_W-1:0] coef;
  logic signed [HW-1:0]     data;
  logic signed [HW-1:0]     sec_y;
  logic                     sec_sat;

  logic        [B0_W-1:0]   b0_sel;
  logic signed [A_W-1:0]    a1_sel, a2_sel;
  logic signed [COEF_W-1:0] b0_c, b1_c;

  logic signed [SB-1:0] fin_y;
  logic                 fin_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == ST_OUT) && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_b0_q <= '0;
      hp_a1_q <= '0;
      hp_a2_q <= '0;
      lp_b0_q <= '0;
      lp_a1_q <= '0;
      lp_a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HP_B0: hp_b0_q <= cfg_wdata_i[B0_W-1:0];
        REG_HP_A1: hp_a1_q <= cfg_wdata_i[A_W-1:0];
        REG_HP_A2: hp_a2_q <= cfg_wdata_i[A_W-1:0];
        REG_LP_B0: lp_b0_q <= cfg_wdata_i[B0_W-1:0];
        REG_LP_A1: lp_a1_q <= cfg_wdata_i[A_W-1:0];
        REG_LP_A2: lp_a2_q <= cfg_wdata_i[A_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    sec_d   = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MAC;
          tap_d   = TAP_X0;
          sec_d   = 1'b0;
        end
      end
      ST_MAC: begin
        if (tap_q == TAP_LAST) begin
          state_d = ST_RND;
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      ST_RND: begin
        if (sec_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MAC;
          tap_d   = TAP_X0;
          sec_d   = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= TAP_X0;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      sec_q   <= sec_d;
    end
  end

  // multiply-accumulate control: products at taps 0..4, each added to the sum in the next cycle
  always_comb begin
    mac_ctrl.mul_en   = (state_q == ST_MAC) && (tap_q != TAP_LAST);
    mac_ctrl.acc_en   = (state_q == ST_MAC) && (tap_q != TAP_X0);
    mac_ctrl.acc_load = (state_q == ST_MAC) && (tap_q == TAP_X1);
  end

  // coefficient operands of the current section
  assign b0_sel = sec_q ? lp_b0_q : hp_b0_q;
  assign a1_sel = sec_q ? lp_a1_q : hp_a1_q;
  assign a2_sel = sec_q ? lp_a2_q : hp_a2_q;
  assign b0_c   = $signed(COEF_W'(b0_sel));
  assign b1_c   = sec_q ? (b0_c <<< 1) : -(b0_c <<< 1);

  // operand select per tap
  always_comb begin
    case (tap_q)
      TAP_X0: begin
        coef = b0_c;
        data = sec_q ? hp_out_q[0] : (HW'(x0_q) <<< GUARD_BITS);
      end
      TAP_X1: begin
        coef = b1_c;
        data = sec_q ? lp_in_q[0] : (HW'(hp_in_q[0]) <<< GUARD_BITS);
      end
      TAP_X2: begin
        coef = b0_c;
        data = sec_q ? lp_in_q[1] : (HW'(hp_in_q[1]) <<< GUARD_BITS);
      end
      TAP_Y1: begin
        coef = -(COEF_W'(a1_sel));
        data = sec_q ? lp_out_q[0] : hp_out_q[0];
      end
      TAP_Y2: begin
        coef = -(COEF_W'(a2_sel));
        data = sec_q ? lp_out_q[1] : hp_out_q[1];
      end
      default: begin
        coef = '0;
        data = '0;
      end
    endcase
  end

  bqc_mac #(
    .HW   (HW),
    .FRAC (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .data_i (data),
    .y_o    (sec_y),
    .sat_o  (sec_sat)
  );

  // history update: cleared on restart, shifted after each section
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_in_q[0]  <= '0;
      hp_in_q[1]  <= '0;
      hp_out_q[0] <= '0;
      hp_out_q[1] <= '0;
      lp_in_q[0]  <= '0;
      lp_in_q[1]  <= '0;
      lp_out_q[0] <= '0;
      lp_out_q[1] <= '0;
    end else if (in_acc && restart_i) begin
      hp_in_q[0]  <= '0;
      hp_in_q[1]  <= '0;
      hp_out_q[0] <= '0;
      hp_out_q[1] <= '0;
      lp_in_q[0]  <= '0;
      lp_in_q[1]  <= '0;
      lp_out_q[0] <= '0;
      lp_out_q[1] <= '0;
    end else if (state_q == ST_RND) begin
      if (sec_q) begin
        lp_in_q[1]  <= lp_in_q[0];
        lp_in_q[0]  <= hp_out_q[0];
        lp_out_q[1] <= lp_out_q[0];
        lp_out_q[0] <= sec_y;
      end else begin
        hp_in_q[1]  <= hp_in_q[0];
        hp_in_q[0]  <= x0_q;
        hp_out_q[1] <= hp_out_q[0];
        hp_out_q[0] <= sec_y;
      end
    end
  end

  // input sample
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q <= sample_in_i;
    end
  end

  // saturation seen during this word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (in_acc) begin
      sat_q <= 1'b0;
    end else if (state_q == ST_RND) begin
      sat_q <= sat_q | sec_sat;
    end
  end

  // final rounding of the guard bits and clamp to the sample width; a plain pass-through when GUARD_BITS is 0
  generate
    if (GUARD_BITS > 0) begin : g_round
      localparam logic signed [HW:0] FIN_HALF = (HW+1)'(1) <<< (GUARD_BITS - 1);
      logic signed [HW:0] fin_sum;
      logic signed [SB:0] fin_sh;
      assign fin_sum = (HW+1)'(lp_out_q[0]) + FIN_HALF;
      assign fin_sh  = (SB+1)'(fin_sum >>> GUARD_BITS);
      assign fin_sat = fin_sh[SB] != fin_sh[SB-1];
      assign fin_y   = !fin_sat ? fin_sh[SB-1:0] :
                       fin_sh[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin : g_pass
      assign fin_sat = 1'b0;
      assign fin_y   = SB'(lp_out_q[0]);
    end
  endgenerate

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_out_q <= fin_y;
      saturated_q  <= sat_q | fin_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

  // checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MAC) && (tap_q == TAP_X0) && !sec_q)
    else $error("word accepted but high-pass section did not start");

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i) |=> (hp_in_q[0] == '0) && (hp_out_q[0] == '0)
      && (lp_in_q[1] == '0) && (lp_out_q[1] == '0))
    else $error("restart did not clear the history");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (tap_q <= TAP_LAST))
    else $error("tap counter ran past the last tap");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("finished word left while the output register was full");

endmodule
